// ----- rtl/core/tlb_with_asid_lru_fifo_unit_macros.svh -----
// assertion macros used by the tlb unit back end rtl
// expects signals clk and rst_n in the including module
`ifndef TLB_WITH_ASID_LRU_FIFO_UNIT_MACROS_SVH
`define TLB_WITH_ASID_LRU_FIFO_UNIT_MACROS_SVH

// same-cycle implication
`define TLBU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlb unit assertion failed");

// next-cycle implication
`define TLBU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlb unit assertion failed");

`endif

// ----- rtl/core/tlbu_pkg.sv -----
// types and constants for the tlb unit
// no dependencies
package tlbu_pkg;

    localparam logic [1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [1:0] KIND_FILL      = 2'd1;
    localparam logic [1:0] KIND_FLUSH     = 2'd2;

    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_LRU  = 2'd1;

    localparam logic [1:0] REG_TLB_ENTRIES = 2'd0;
    localparam logic [1:0] REG_POLICY      = 2'd1;
    localparam logic [1:0] REG_PAGE_SIZE   = 2'd2;

    localparam logic [4:0]  RST_TLB_ENTRIES = 5'd4;
    localparam logic [1:0]  RST_POLICY      = POLICY_LRU;
    localparam logic [16:0] RST_PAGE_SIZE   = 17'd4096;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [31:0] logical_address;
        logic [19:0] frame;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [35:0] physical_address;
        logic [31:0] page_number;
    } rsp_t;

    typedef struct packed {
        logic [4:0] tlb_entries;
        logic [1:0] replace_policy;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [19:0] frame;
        logic [31:0] page;
        logic [16:0] offset;
        logic [16:0] psize;
    } q_item_t;

endpackage

// ----- rtl/core/tlb_with_asid_lru_fifo_unit.sv -----
// a request goes through the front end page divider, the queue, and back end states exec,
// srch only on a fill with no free entry, mul and out; start is taken only while not busy
// a queued request overlaps the back end, whose search walks one entry per cycle
// async active-low rst_n invalidates all entries, resets counters, state and config to defaults
// results are strobed for one cycle on done; the receiver cannot stall
module tlb_with_asid_lru_fifo_unit
#(
    parameter int TLB_DEPTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tlbu_pkg::req_t req,
    output logic           done,
    output tlbu_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [4:0]        entries_reg;
    logic [1:0]        policy_reg;
    logic [16:0]       psize_reg;
    logic              wr;
    tlbu_pkg::cfg_t    cfg;
    tlbu_pkg::q_item_t f_item, q_head;
    logic              f_push, q_full, q_empty, q_pop;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign cfg    = '{tlb_entries: entries_reg, replace_policy: policy_reg};

    always_comb
    begin
        case (paddr[3:2])
            tlbu_pkg::REG_TLB_ENTRIES: prdata = {27'd0, entries_reg};
            tlbu_pkg::REG_POLICY:      prdata = {30'd0, policy_reg};
            tlbu_pkg::REG_PAGE_SIZE:   prdata = {15'd0, psize_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= tlbu_pkg::RST_TLB_ENTRIES;
            policy_reg  <= tlbu_pkg::RST_POLICY;
            psize_reg   <= tlbu_pkg::RST_PAGE_SIZE;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                tlbu_pkg::REG_TLB_ENTRIES: entries_reg <= pwdata[4:0];
                tlbu_pkg::REG_POLICY:      policy_reg  <= pwdata[1:0];
                tlbu_pkg::REG_PAGE_SIZE:   psize_reg   <= pwdata[16:0];
                default:                   ;
            endcase
        end
    end

    tlbu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .page_size (psize_reg),
        .push      (f_push),
        .item      (f_item),
        .q_full    (q_full)
    );

    tlbu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tlbu_back #(.TLB_DEPTH(TLB_DEPTH)) u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (q_head),
        .empty (q_empty),
        .pop   (q_pop),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// ----- rtl/core/tlbu_front.sv -----
// front end: accepts requests and splits the address by the page size
// depends on tlbu_pkg
module tlbu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tlbu_pkg::req_t   req,
    input  logic [16:0]      page_size,
    output logic             push,
    output tlbu_pkg::q_item_t item,
    input  logic             q_full
);

    logic        div_reg, div_next;
    logic        hold_reg, hold_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] psize_reg, psize_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] pid_reg, pid_next;
    logic [19:0] frame_reg, frame_next;
    logic [17:0] rem_sh;
    logic        ge;

    assign busy = div_reg | hold_reg;
    assign push = hold_reg & ~q_full;
    assign item = '{kind: kind_reg, pid: pid_reg, frame: frame_reg, page: quo_reg,
                    offset: rem_reg, psize: psize_reg};

    assign rem_sh = {rem_reg, addr_reg[31]};
    assign ge     = rem_sh >= {1'b0, psize_reg};

    always_comb
    begin
        div_next   = div_reg;
        hold_next  = hold_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        psize_next = psize_reg;
        kind_next  = kind_reg;
        pid_next   = pid_reg;
        frame_next = frame_reg;
        if (start && !busy)
        begin
            div_next   = 1'b1;
            cnt_next   = 5'd0;
            addr_next  = req.logical_address;
            quo_next   = 32'd0;
            rem_next   = 17'd0;
            psize_next = (page_size == 17'd0) ? 17'd1 : page_size;
            kind_next  = req.kind;
            pid_next   = req.pid;
            frame_next = req.frame;
        end
        else if (div_reg)
        begin
            rem_next  = ge ? 17'(rem_sh - {1'b0, psize_reg}) : rem_sh[16:0];
            quo_next  = {quo_reg[30:0], ge};
            addr_next = {addr_reg[30:0], 1'b0};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                div_next  = 1'b0;
                hold_next = 1'b1;
            end
        end
        else if (push)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= 1'b0;
            hold_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            div_reg  <= div_next;
            hold_reg <= hold_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        psize_reg <= psize_next;
        kind_reg  <= kind_next;
        pid_reg   <= pid_next;
        frame_reg <= frame_next;
    end

endmodule

// ----- rtl/core/tlbu_queue.sv -----
// two-entry request queue between front and back end
// depends on tlbu_pkg
module tlbu_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlbu_pkg::q_item_t push_item,
    input  logic              pop,
    output tlbu_pkg::q_item_t head,
    output logic              full,
    output logic              empty
);

    tlbu_pkg::q_item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/tlbu_back.sv -----
// back end: entry store, lookup, fill with victim search, flush, address build
// depends on tlbu_pkg and tlb_with_asid_lru_fifo_unit_macros.svh
`include "tlb_with_asid_lru_fifo_unit_macros.svh"

module tlbu_back
#(
    parameter int TLB_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tlbu_pkg::cfg_t    cfg,
    input  tlbu_pkg::q_item_t head,
    input  logic              empty,
    output logic              pop,
    output logic              done,
    output tlbu_pkg::rsp_t    rsp
);

    localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CNT_W = $clog2(TLB_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             st_reg, st_next;
    tlbu_pkg::q_item_t      item_reg, item_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [1:0]             pol_reg, pol_next;
    logic                   hit_reg, hit_next;
    logic                   pa_en_reg, pa_en_next;
    logic [19:0]            fr_reg, fr_next;
    logic [36:0]            prod_reg, prod_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       best_reg, best_next;
    logic [31:0]            use_cnt_reg, use_cnt_next;
    logic [31:0]            ins_cnt_reg, ins_cnt_next;
    logic                   done_reg, done_next;
    tlbu_pkg::rsp_t         rsp_reg, rsp_next;

    logic [TLB_DEPTH-1:0]   valid_reg, valid_next;
    logic [15:0]            pid_mem [TLB_DEPTH];
    logic [31:0]            page_mem [TLB_DEPTH];
    logic [19:0]            frame_mem [TLB_DEPTH];
    logic [31:0]            use_mem [TLB_DEPTH];
    logic [31:0]            ins_mem [TLB_DEPTH];

    logic [TLB_DEPTH-1:0]   act, match, free, fl;
    logic                   wr_en, stamp_en;
    logic [IDX_W-1:0]       wr_idx, stamp_idx, cand;
    logic [31:0]            key_i, key_b;

    function automatic logic [IDX_W-1:0] lowest(input logic [TLB_DEPTH-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = TLB_DEPTH - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = IDX_W'(k);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < TLB_DEPTH; i++)
        begin
            act[i]   = 32'(i) < 32'(n_reg);
            match[i] = act[i] && valid_reg[i] && page_mem[i] == item_reg.page
                       && pid_mem[i] == item_reg.pid;
            free[i]  = act[i] && !valid_reg[i];
            fl[i]    = act[i] && valid_reg[i] && pid_mem[i] == item_reg.pid;
        end
    end

    assign key_i = (pol_reg == tlbu_pkg::POLICY_FIFO) ? ins_mem[idx_reg] : use_mem[idx_reg];
    assign key_b = (pol_reg == tlbu_pkg::POLICY_FIFO) ? ins_mem[best_reg] : use_mem[best_reg];
    assign cand  = (key_i < key_b) ? idx_reg : best_reg;

    assign pop  = (st_reg == S_IDLE) && !empty;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        st_next      = st_reg;
        item_next    = item_reg;
        n_next       = n_reg;
        pol_next     = pol_reg;
        hit_next     = hit_reg;
        pa_en_next   = pa_en_reg;
        fr_next      = fr_reg;
        prod_next    = prod_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        use_cnt_next = use_cnt_reg;
        ins_cnt_next = ins_cnt_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        wr_en        = 1'b0;
        wr_idx       = '0;
        stamp_en     = 1'b0;
        stamp_idx    = '0;
        case (st_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    item_next = head;
                    n_next    = (32'(cfg.tlb_entries) > 32'(TLB_DEPTH)) ?
                                CNT_W'(TLB_DEPTH) : CNT_W'(cfg.tlb_entries);
                    pol_next  = cfg.replace_policy;
                    st_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                hit_next   = 1'b0;
                pa_en_next = 1'b0;
                fr_next    = item_reg.frame;
                st_next    = S_MUL;
                if (item_reg.kind == tlbu_pkg::KIND_TRANSLATE)
                begin
                    if (|match)
                    begin
                        stamp_en     = 1'b1;
                        stamp_idx    = lowest(match);
                        use_cnt_next = use_cnt_reg + 32'd1;
                        hit_next     = 1'b1;
                        pa_en_next   = 1'b1;
                        fr_next      = frame_mem[lowest(match)];
                    end
                end
                else if (item_reg.kind == tlbu_pkg::KIND_FILL)
                begin
                    pa_en_next = 1'b1;
                    if (n_reg != '0)
                    begin
                        if (|free)
                        begin
                            wr_en  = 1'b1;
                            wr_idx = lowest(free);
                        end
                        else if (pol_reg > tlbu_pkg::POLICY_LRU || n_reg == CNT_W'(1))
                        begin
                            wr_en  = 1'b1;
                            wr_idx = '0;
                        end
                        else
                        begin
                            idx_next  = IDX_W'(1);
                            best_next = '0;
                            st_next   = S_SRCH;
                        end
                    end
                end
                else if (item_reg.kind == tlbu_pkg::KIND_FLUSH)
                begin
                    valid_next = valid_reg & ~fl;
                end
            end
            S_SRCH:
            begin
                best_next = cand;
                idx_next  = idx_reg + IDX_W'(1);
                if (32'(idx_reg) + 32'd1 == 32'(n_reg))
                begin
                    wr_en   = 1'b1;
                    wr_idx  = cand;
                    st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = 37'(fr_reg) * 37'(item_reg.psize);
                st_next   = S_OUT;
            end
            S_OUT:
            begin
                done_next                 = 1'b1;
                rsp_next.hit              = hit_reg;
                rsp_next.physical_address = pa_en_reg ?
                    36'(prod_reg) + 36'(item_reg.offset) : 36'd0;
                rsp_next.page_number      =
                    (item_reg.kind == tlbu_pkg::KIND_TRANSLATE ||
                     item_reg.kind == tlbu_pkg::KIND_FILL) ? item_reg.page : 32'd0;
                st_next                   = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
            use_cnt_next       = use_cnt_reg + 32'd1;
            ins_cnt_next       = ins_cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            valid_reg   <= '0;
            use_cnt_reg <= 32'd0;
            ins_cnt_reg <= 32'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            valid_reg   <= valid_next;
            use_cnt_reg <= use_cnt_next;
            ins_cnt_reg <= ins_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        n_reg     <= n_next;
        pol_reg   <= pol_next;
        hit_reg   <= hit_next;
        pa_en_reg <= pa_en_next;
        fr_reg    <= fr_next;
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        rsp_reg   <= rsp_next;
        if (wr_en)
        begin
            pid_mem[wr_idx]   <= item_reg.pid;
            page_mem[wr_idx]  <= item_reg.page;
            frame_mem[wr_idx] <= item_reg.frame;
            use_mem[wr_idx]   <= use_cnt_reg;
            ins_mem[wr_idx]   <= ins_cnt_reg;
        end
        if (stamp_en)
        begin
            use_mem[stamp_idx] <= use_cnt_reg;
        end
    end

    `TLBU_ASSERT_NXT(a_done_single, done_reg, !done_reg)
    `TLBU_ASSERT_IMP(a_hit_translate, done_reg && rsp_reg.hit,
                     item_reg.kind == tlbu_pkg::KIND_TRANSLATE)
    `TLBU_ASSERT_NXT(a_pop_starts, pop, st_reg == S_EXEC)
    `TLBU_ASSERT_IMP(a_one_write, wr_en || stamp_en, !(wr_en && stamp_en))

endmodule
